// ===== src/genomic_site_block_merger_core_macros.svh =====
// Assertion helpers for the site block merger.
`ifndef GENOMIC_SITE_BLOCK_MERGER_CORE_MACROS_SVH
`define GENOMIC_SITE_BLOCK_MERGER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GSBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsbm: same-cycle check failed");
`define GSBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsbm: next-cycle check failed");
`else
`define GSBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GSBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/gsbm_pkg.sv =====
`default_nettype none

package gsbm_pkg;

    localparam int POS_W    = 32;
    localparam int FILT_W   = 16;
    localparam int GT_W     = 8;
    localparam int FIELD_W  = 16;
    localparam int COUNT_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int ABS_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAC_SCALE = 2'd0,
        CFG_ABS_TOL    = 2'd1
    } cfg_index_t;

    localparam logic [FRAC_W-1:0] FRAC_SCALE_RESET = 16'd19661;
    localparam logic [ABS_W-1:0]  ABS_TOL_RESET    = 8'd3;

endpackage

`default_nettype wire

// ===== src/gsbm_site_if.sv =====
`default_nettype none

interface gsbm_site_if;
    import gsbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [FILT_W-1:0]   filter_mask;
    logic [GT_W-1:0]     genotype_code;
    logic                any_coverage;
    logic                used_coverage;
    logic                has_quality;
    logic [FIELD_W-1:0]  quality;
    logic [FIELD_W-1:0]  used_depth;
    logic [FIELD_W-1:0]  unused_depth;

    modport source (
        output valid, position, filter_mask, genotype_code, any_coverage,
               used_coverage, has_quality, quality, used_depth, unused_depth,
        input  ready
    );

    modport sink (
        input  valid, position, filter_mask, genotype_code, any_coverage,
               used_coverage, has_quality, quality, used_depth, unused_depth,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/gsbm_result_if.sv =====
`default_nettype none

interface gsbm_result_if;
    import gsbm_pkg::*;

    logic                valid;
    logic                ready;
    logic                starts_new_block;
    logic [POS_W-1:0]    closed_start;
    logic [COUNT_W-1:0]  closed_length;
    logic [FIELD_W-1:0]  closed_min_quality;
    logic [FIELD_W-1:0]  closed_min_used_depth;
    logic [FIELD_W-1:0]  closed_min_unused_depth;
    logic [COUNT_W-1:0]  current_length;

    modport source (
        output valid, starts_new_block, closed_start, closed_length, closed_min_quality,
               closed_min_used_depth, closed_min_unused_depth, current_length,
        input  ready
    );

    modport sink (
        input  valid, starts_new_block, closed_start, closed_length, closed_min_quality,
               closed_min_used_depth, closed_min_unused_depth, current_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/genomic_site_block_merger_core.sv =====
// Channel  | Dir | Handshake     | Word
// site     | in  | valid/ready   | one genomic site
// result   | out | valid/ready   | block decision for that site
// cfg      | in  | cfg_we only   | tolerance register write
//
// One site per cycle while the result is not stalled; an accepted site sits in the
// input register and moves to the result register when it fires (decision + block
// state update). The block state loop (contiguity, min/max, tolerance multiply)
// is combinational, so back-to-back sites see each other's updates.
// Reset (rst_n low, async) empties both registers and restores block state.
// A stalled result holds the input register; the site side stalls only then.
`default_nettype none

`include "genomic_site_block_merger_core_macros.svh"

module genomic_site_block_merger_core #(
    parameter int VALUE_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    gsbm_site_if.sink                         site,
    gsbm_result_if.source                     result,
    input  wire                               cfg_we,
    input  wire [gsbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [gsbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gsbm_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int CW = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam logic [VB-1:0]      VMAX      = {VB{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [VB-1:0] val_t;

    function automatic val_t clampv(input logic [FIELD_W-1:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] vm;
        ve = CW'(v);
        vm = CW'(VMAX);
        return (ve > vm) ? VMAX : VB'(ve);
    endfunction

    function automatic logic tol_ok(input val_t mn, input val_t mx, input val_t v,
                                    input logic [FRAC_W-1:0] frac,
                                    input logic [ABS_W-1:0] abs_tol);
        val_t                  m;
        val_t                  x;
        logic [VB+1:0]         lim_abs;
        logic [VB+FRAC_W-1:0]  prod;
        val_t                  f;
        logic [VB+1:0]         lim_frac;
        m = (v < mn) ? v : mn;
        x = (v > mx) ? v : mx;
        lim_abs  = ((VB+2)'(m) + (VB+2)'(abs_tol)) << 1;
        prod     = (VB+FRAC_W)'(m) * (VB+FRAC_W)'(frac);
        f        = prod[VB+FRAC_W-1:FRAC_W];
        lim_frac = ((VB+2)'(m) + (VB+2)'(f)) << 1;
        if (lim_abs >= (VB+2)'(x))
            return 1'b1;
        else if (f <= VB'(abs_tol))
            return 1'b0;
        else
            return lim_frac >= (VB+2)'(x);
    endfunction

    // config
    logic [FRAC_W-1:0] frac_scale_reg;
    logic [ABS_W-1:0]  abs_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_scale_reg <= FRAC_SCALE_RESET;
            abs_tol_reg    <= ABS_TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAC_SCALE: frac_scale_reg <= FRAC_W'(cfg_data);
                CFG_ABS_TOL:    abs_tol_reg    <= ABS_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // input register
    logic                s1_vld_reg;
    logic [POS_W-1:0]    s1_pos_reg;
    logic [FILT_W-1:0]   s1_filt_reg;
    logic [GT_W-1:0]     s1_gt_reg;
    logic [1:0]          s1_cov_reg;
    logic                s1_hq_reg;
    val_t                s1_q_reg;
    val_t                s1_du_reg;
    val_t                s1_df_reg;

    logic fire;
    logic take;

    assign fire       = s1_vld_reg && (!result.valid || result.ready);
    assign site.ready = !s1_vld_reg || fire;
    assign take       = site.valid && site.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (take)
            s1_vld_reg <= 1'b1;
        else if (fire)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pos_reg  <= site.position;
            s1_filt_reg <= site.filter_mask;
            s1_gt_reg   <= site.genotype_code;
            s1_cov_reg  <= {site.used_coverage, site.any_coverage};
            s1_hq_reg   <= site.has_quality;
            s1_q_reg    <= clampv(site.quality);
            s1_du_reg   <= clampv(site.used_depth);
            s1_df_reg   <= clampv(site.unused_depth);
        end
    end

    // block state
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [POS_W-1:0]   start_reg,    start_next;
    logic [FILT_W-1:0]  filt_reg,     filt_next;
    logic [GT_W-1:0]    gt_reg,       gt_next;
    logic [1:0]         cov_reg,      cov_next;
    logic               hq_reg,       hq_next;
    val_t               qmin_reg,     qmin_next;
    val_t               qmax_reg,     qmax_next;
    val_t               umin_reg,     umin_next;
    val_t               umax_reg,     umax_next;
    val_t               fmin_reg,     fmin_next;
    val_t               fmax_reg,     fmax_next;

    logic               extend;
    logic               match;
    logic [COUNT_W-1:0] base_count;
    val_t               qmin_b, qmax_b, umin_b, umax_b, fmin_b, fmax_b;

    always_comb
    begin
        match = (start_reg + count_reg == s1_pos_reg)
             && (filt_reg == s1_filt_reg)
             && (gt_reg == s1_gt_reg)
             && (cov_reg == s1_cov_reg)
             && (hq_reg == s1_hq_reg)
             && (!s1_hq_reg || tol_ok(qmin_reg, qmax_reg, s1_q_reg,
                                      frac_scale_reg, abs_tol_reg))
             && tol_ok(umin_reg, umax_reg, s1_du_reg, frac_scale_reg, abs_tol_reg)
             && tol_ok(fmin_reg, fmax_reg, s1_df_reg, frac_scale_reg, abs_tol_reg);
        extend = (count_reg == '0) || match;

        count_next = count_reg;
        start_next = start_reg;
        filt_next  = filt_reg;
        gt_next    = gt_reg;
        cov_next   = cov_reg;
        hq_next    = hq_reg;
        qmin_next  = qmin_reg;
        qmax_next  = qmax_reg;
        umin_next  = umin_reg;
        umax_next  = umax_reg;
        fmin_next  = fmin_reg;
        fmax_next  = fmax_reg;

        // a site that cannot extend, or the first site, reopens the block
        base_count = extend ? count_reg : '0;
        if (base_count == '0)
        begin
            qmin_b = VMAX;
            qmax_b = '0;
            umin_b = VMAX;
            umax_b = '0;
            fmin_b = VMAX;
            fmax_b = '0;
        end
        else
        begin
            qmin_b = qmin_reg;
            qmax_b = qmax_reg;
            umin_b = umin_reg;
            umax_b = umax_reg;
            fmin_b = fmin_reg;
            fmax_b = fmax_reg;
        end

        if (fire)
        begin
            if (base_count == '0)
            begin
                start_next = s1_pos_reg;
                filt_next  = s1_filt_reg;
                gt_next    = s1_gt_reg;
                cov_next   = s1_cov_reg;
                hq_next    = s1_hq_reg;
            end
            qmin_next = (s1_hq_reg && s1_q_reg < qmin_b) ? s1_q_reg : qmin_b;
            qmax_next = (s1_hq_reg && s1_q_reg > qmax_b) ? s1_q_reg : qmax_b;
            umin_next = (s1_du_reg < umin_b) ? s1_du_reg : umin_b;
            umax_next = (s1_du_reg > umax_b) ? s1_du_reg : umax_b;
            fmin_next = (s1_df_reg < fmin_b) ? s1_df_reg : fmin_b;
            fmax_next = (s1_df_reg > fmax_b) ? s1_df_reg : fmax_b;
            count_next = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            start_reg <= '0;
            filt_reg  <= '0;
            gt_reg    <= '0;
            cov_reg   <= '0;
            hq_reg    <= 1'b0;
            qmin_reg  <= VMAX;
            qmax_reg  <= '0;
            umin_reg  <= VMAX;
            umax_reg  <= '0;
            fmin_reg  <= VMAX;
            fmax_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            start_reg <= start_next;
            filt_reg  <= filt_next;
            gt_reg    <= gt_next;
            cov_reg   <= cov_next;
            hq_reg    <= hq_next;
            qmin_reg  <= qmin_next;
            qmax_reg  <= qmax_next;
            umin_reg  <= umin_next;
            umax_reg  <= umax_next;
            fmin_reg  <= fmin_next;
            fmax_reg  <= fmax_next;
        end
    end

    // result register
    logic                out_vld_reg, out_vld_next;
    logic                out_new_reg;
    logic [POS_W-1:0]    out_start_reg;
    logic [COUNT_W-1:0]  out_len_reg;
    logic [FIELD_W-1:0]  out_qmin_reg;
    logic [FIELD_W-1:0]  out_umin_reg;
    logic [FIELD_W-1:0]  out_fmin_reg;
    logic [COUNT_W-1:0]  out_cur_reg;

    always_comb
    begin
        if (fire)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_new_reg   <= !extend;
            out_start_reg <= extend ? '0 : start_reg;
            out_len_reg   <= extend ? '0 : count_reg;
            out_qmin_reg  <= (extend || !hq_reg) ? '0 : FIELD_W'(qmin_reg);
            out_umin_reg  <= extend ? '0 : FIELD_W'(umin_reg);
            out_fmin_reg  <= extend ? '0 : FIELD_W'(fmin_reg);
            out_cur_reg   <= count_next;
        end
    end

    assign result.valid                   = out_vld_reg;
    assign result.starts_new_block        = out_new_reg;
    assign result.closed_start            = out_start_reg;
    assign result.closed_length           = out_len_reg;
    assign result.closed_min_quality      = out_qmin_reg;
    assign result.closed_min_used_depth   = out_umin_reg;
    assign result.closed_min_unused_depth = out_fmin_reg;
    assign result.current_length          = out_cur_reg;

    `GSBM_ASSERT_NEXT(a_fire_loads_result, clk, rst_n, fire, out_vld_reg)
    `GSBM_ASSERT_IMPL(a_closed_nonempty, clk, rst_n, out_vld_reg && out_new_reg, out_len_reg != '0)
    `GSBM_ASSERT_IMPL(a_open_nonempty, clk, rst_n, out_vld_reg, out_cur_reg != '0)
    `GSBM_ASSERT_IMPL(a_empty_in_ready, clk, rst_n, !s1_vld_reg, site.ready)

endmodule

`default_nettype wire
